FILE: hw/rtl/dsv_pkg.sv
// dsv_pkg: constants and helpers for the date string validator
// no dependencies
package dsv_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned DigitW = 4;
  localparam int unsigned NumDigits = 8;
  localparam int unsigned CountW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned PairW  = 7;
  localparam int unsigned FmtW   = 2;
  localparam int unsigned PaddrW = 3;

  localparam logic [CountW-1:0] COUNT_MAX  = 4'd15;
  localparam logic [CountW-1:0] LEN_YMD    = 4'd8;
  localparam logic [CountW-1:0] LEN_MD     = 4'd4;

  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CharW-1:0] CHAR_NUL   = 8'h00;

  localparam logic [FmtW-1:0] FMT_YMD_ONLY = 2'd1;
  localparam logic [FmtW-1:0] FMT_MD_ONLY  = 2'd2;

  localparam logic REG_IDX_FORMAT = 1'b0;

  localparam logic [PairW-1:0] MONTH_FEB  = 7'd2;
  localparam logic [PairW-1:0] MONTH_LAST = 7'd12;
  localparam logic [DayW-1:0]  DAYS_FEB_LEAP = 5'd29;

  typedef logic [DigitW-1:0] digit_t;

  function automatic logic [DayW-1:0] days_in_month(input logic [MonthW-1:0] m);
    logic [DayW-1:0] r;
    case (m)
      4'd2:                      r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic [PairW-1:0] pair(input digit_t hi, input digit_t lo);
    return PairW'({3'b000, hi}) * PairW'(10) + PairW'({3'b000, lo});
  endfunction

endpackage

FILE: hw/rtl/dsv_if.sv
// dsv_char_if / dsv_result_if: valid-ready channels for characters and results
// depends on dsv_pkg
interface dsv_char_if;
  logic                      valid;
  logic                      ready;
  logic [dsv_pkg::CharW-1:0] char_code;
  logic                      end_of_string;

  modport source (output valid, char_code, end_of_string, input ready);
  modport sink   (input valid, char_code, end_of_string, output ready);
endinterface

interface dsv_result_if;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic [dsv_pkg::YearW-1:0]  year_value;
  logic [dsv_pkg::MonthW-1:0] month_value;
  logic [dsv_pkg::DayW-1:0]   day_value;
  logic                       year_present;

  modport source (output valid, status, year_value, month_value, day_value, year_present,
                  input ready);
  modport sink   (input valid, status, year_value, month_value, day_value, year_present,
                  output ready);
endinterface

FILE: hw/rtl/date_string_validator.sv
// date_string_validator: one character per cycle, one result word per string
// result path: a finished string is captured in the snapshot register, then its checked result in the result register
// throughput: one character per cycle, stalls only when the result register is held
// reset: asynchronous active low, clears digit store, count, flags and format register
// depends on dsv_pkg, dsv_if
module date_string_validator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dsv_char_if.sink                    in_i,
  dsv_result_if.source                res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dsv_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned N = dsv_pkg::NumDigits;

  logic [dsv_pkg::FmtW-1:0] fmt_q;

  dsv_pkg::digit_t              dig_q [N];
  dsv_pkg::digit_t              dig_d [N];
  logic [dsv_pkg::CountW-1:0]   cnt_q, cnt_d;
  logic                         nd_q, nd_d;

  logic                         s1_vld_q;
  dsv_pkg::digit_t              s1_dig_q [N];
  logic [dsv_pkg::CountW-1:0]   s1_cnt_q;
  logic                         s1_nd_q;

  logic                         out_vld_q;
  logic                         out_status_q;
  logic [dsv_pkg::YearW-1:0]    out_year_q;
  logic [dsv_pkg::MonthW-1:0]   out_month_q;
  logic [dsv_pkg::DayW-1:0]     out_day_q;
  logic                         out_yp_q;

  logic out_free, s1_adv, in_acc, is_dig, is_term;

  // apb register
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == dsv_pkg::REG_IDX_FORMAT) begin
      prdata = {30'd0, fmt_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == dsv_pkg::REG_IDX_FORMAT) begin
      fmt_q <= pwdata[dsv_pkg::FmtW-1:0];
    end
  end

  // handshake
  assign out_free  = !out_vld_q || res_o.ready;
  assign s1_adv    = s1_vld_q && out_free;
  assign in_i.ready = !s1_vld_q || out_free;
  assign in_acc    = in_i.valid && in_i.ready;

  // character accumulation
  assign is_term = in_i.end_of_string && (in_i.char_code == dsv_pkg::CHAR_NUL);
  assign is_dig  = (in_i.char_code >= dsv_pkg::CHAR_ZERO) &&
                   (in_i.char_code <= dsv_pkg::CHAR_NINE);

  always_comb begin
    dig_d = dig_q;
    cnt_d = cnt_q;
    nd_d  = nd_q;
    if (!is_term) begin
      if (is_dig && cnt_q < dsv_pkg::LEN_YMD) begin
        dig_d[cnt_q[2:0]] = in_i.char_code[dsv_pkg::DigitW-1:0];
      end
      if (!is_dig) begin
        nd_d = 1'b1;
      end
      if (cnt_q != dsv_pkg::COUNT_MAX) begin
        cnt_d = cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        dig_q[i] <= '0;
      end
      cnt_q <= '0;
      nd_q  <= 1'b0;
    end else if (in_acc) begin
      if (in_i.end_of_string) begin
        for (int i = 0; i < N; i++) begin
          dig_q[i] <= '0;
        end
        cnt_q <= '0;
        nd_q  <= 1'b0;
      end else begin
        dig_q <= dig_d;
        cnt_q <= cnt_d;
        nd_q  <= nd_d;
      end
    end
  end

  // snapshot of a finished string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_acc && in_i.end_of_string;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.end_of_string) begin
      s1_dig_q <= dig_d;
      s1_cnt_q <= cnt_d;
      s1_nd_q  <= nd_d;
    end
  end

  // date check
  logic [dsv_pkg::PairW-1:0]  yhi, ylo, mon, day;
  logic [dsv_pkg::YearW-1:0]  year;
  logic                       is8, is4, leap, feb29, md_ok, ok;
  logic [dsv_pkg::DayW-1:0]   limit;

  always_comb begin
    is8  = !s1_nd_q && (s1_cnt_q == dsv_pkg::LEN_YMD) && (fmt_q != dsv_pkg::FMT_MD_ONLY);
    is4  = !s1_nd_q && (s1_cnt_q == dsv_pkg::LEN_MD) && (fmt_q != dsv_pkg::FMT_YMD_ONLY);
    yhi  = dsv_pkg::pair(s1_dig_q[0], s1_dig_q[1]);
    ylo  = dsv_pkg::pair(s1_dig_q[2], s1_dig_q[3]);
    year = dsv_pkg::YearW'(yhi) * dsv_pkg::YearW'(100) + dsv_pkg::YearW'(ylo);
    mon  = is8 ? dsv_pkg::pair(s1_dig_q[4], s1_dig_q[5]) : yhi;
    day  = is8 ? dsv_pkg::pair(s1_dig_q[6], s1_dig_q[7]) : ylo;
    leap = (ylo != '0) ? (ylo[1:0] == 2'b00) : (yhi[1:0] == 2'b00);
    feb29 = !is8 || leap;
    limit = dsv_pkg::days_in_month(mon[dsv_pkg::MonthW-1:0]);
    if (mon == dsv_pkg::MONTH_FEB && feb29) begin
      limit = dsv_pkg::DAYS_FEB_LEAP;
    end
    md_ok = (mon != '0) && (mon <= dsv_pkg::MONTH_LAST) && (day != '0) &&
            (day <= dsv_pkg::PairW'(limit));
    ok = (is8 && (year != '0) && md_ok) || (is4 && md_ok);
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_status_q <= !ok;
      out_year_q   <= (ok && is8) ? year : '0;
      out_month_q  <= ok ? mon[dsv_pkg::MonthW-1:0] : '0;
      out_day_q    <= ok ? day[dsv_pkg::DayW-1:0] : '0;
      out_yp_q     <= ok && is8;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.status       = out_status_q;
  assign res_o.year_value   = out_year_q;
  assign res_o.month_value  = out_month_q;
  assign res_o.day_value    = out_day_q;
  assign res_o.year_present = out_yp_q;

endmodule
